FILE: rtl/core/sdit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdit_pkg
// Shared types and constants of the sorted descending insert table.
// ----------------------------------------------------------------------------
package sdit_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int KEY_W        = 64;
  localparam int HANDLE_W     = 32;
  localparam int POS_OUT_W    = 9;
  localparam int ACT_W        = 3;
  localparam int COUNT_OUT_W  = 9;
  localparam int IN_DATA_W    = 96;
  localparam int OUT_DATA_W   = 24;

  localparam logic [KEY_W-1:0] KEY_DEFAULT = {KEY_W{1'b1}};

  typedef enum logic [ACT_W-1:0] {
    ACT_IGNORED  = 3'd0,
    ACT_REPLACED = 3'd1,
    ACT_INSERTED = 3'd2,
    ACT_APPENDED = 3'd3,
    ACT_FULL     = 3'd4
  } action_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;  // capture compare flags against the broadcast key
    logic write;   // commit the request into the row
    logic shift;   // cells past the slot take their upper neighbor
  } cell_ctl_t;

endpackage

FILE: rtl/core/sdit_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdit_cell
// One table slot: holds a key and handle, compares against the broadcast key
// and takes its upper neighbor's entry when an insert shifts the row down.
// ----------------------------------------------------------------------------
module sdit_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  sdit_pkg::cell_ctl_t            ctl,
  input  logic [sdit_pkg::KEY_W-1:0]     new_key,
  input  logic [sdit_pkg::HANDLE_W-1:0]  new_handle,
  input  logic                           live,
  input  logic                           prev_gt,
  input  logic [sdit_pkg::KEY_W-1:0]     prev_key,
  input  logic [sdit_pkg::HANDLE_W-1:0]  prev_handle,
  output logic                           gt,
  output logic                           hit,
  output logic                           eq,
  output logic [sdit_pkg::KEY_W-1:0]     key,
  output logic [sdit_pkg::HANDLE_W-1:0]  handle
);

  logic gt_next;
  logic eq_next;

  // Sign-flipped unsigned compare gives signed order.
  assign gt_next = live &&
                   ({~key[sdit_pkg::KEY_W-1], key[sdit_pkg::KEY_W-2:0]} >
                    {~new_key[sdit_pkg::KEY_W-1], new_key[sdit_pkg::KEY_W-2:0]});
  assign eq_next = live && (key == new_key);

  // First cell whose key is not greater than the new key.
  assign hit = prev_gt && !gt;

  always_ff @(posedge clk) begin
    if (rst) begin
      gt <= 1'b0;
      eq <= 1'b0;
    end else if (ctl.cmp_en) begin
      gt <= gt_next;
      eq <= eq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      if (hit) begin
        key    <= new_key;
        handle <= new_handle;
      end else if (ctl.shift && !gt) begin
        key    <= prev_key;
        handle <= prev_handle;
      end
    end
  end

endmodule

FILE: rtl/core/sorted_descending_insert_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_descending_insert_table
// Table of keyed handles kept in descending key order by a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one request per item, key and handle in tdata.
//   Output stream m_axis_*: one result per request (position, action, count).
//   A key of all ones is ignored and leaves the table unchanged.
//   Each request steps through accept, compare in every cell, encode the
//   slot, then commit. The row of cells compares against the broadcast key
//   in parallel and shifts down by one cell on an insert; the slot encoder
//   over CAPACITY hit flags has a state of its own. A new request is taken
//   only once the previous one has committed.
//   Results sit in an output register; the next request is accepted while a
//   result waits, but the commit of that next request holds until the
//   output register is free, so a stalled receiver stalls the input.
//   Reset empties the table (count zero) and clears the output register; no
//   clearing pass is needed since only entries below the count are compared.
//   A growing request into a full table is refused with no change.
// ----------------------------------------------------------------------------
module sorted_descending_insert_table #(
  parameter int CAPACITY = sdit_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [63:0] entry_key, [95:64] entry_handle
  input  logic [sdit_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [8:0] position, [11:9] action, [20:12] entry_count, [23:21] zero
  output logic [sdit_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CMP    = 4'b0010,
    ST_DEC    = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [sdit_pkg::KEY_W-1:0]    req_key;
  logic [sdit_pkg::HANDLE_W-1:0] req_handle;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 pos;
  logic [CW-1:0]                 pos_next;
  sdit_pkg::action_t             act;
  sdit_pkg::action_t             act_next;
  logic                          out_free;
  logic                          commit;
  logic                          grow;
  sdit_pkg::cell_ctl_t           ctl;

  logic [CAPACITY-1:0]           live;
  logic [CAPACITY-1:0]           gt;
  logic [CAPACITY-1:0]           hit;
  logic [CAPACITY-1:0]           eq;
  logic [CAPACITY-1:0]           prev_gt;
  logic [sdit_pkg::KEY_W-1:0]    key_row    [CAPACITY];
  logic [sdit_pkg::HANDLE_W-1:0] handle_row [CAPACITY];
  logic [sdit_pkg::KEY_W-1:0]    prev_key   [CAPACITY];
  logic [sdit_pkg::HANDLE_W-1:0] prev_handle[CAPACITY];

  logic                          out_valid;
  logic [sdit_pkg::POS_OUT_W-1:0]   out_pos;
  sdit_pkg::action_t                out_act;
  logic [sdit_pkg::COUNT_OUT_W-1:0] out_count;

  logic [CW-1:0] enc_pos;
  logic          repl;

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign out_free      = !out_valid || m_axis_tready;
  assign commit        = (state == ST_COMMIT) && out_free;
  assign grow          = (act == sdit_pkg::ACT_INSERTED) || (act == sdit_pkg::ACT_APPENDED);

  assign ctl.cmp_en = (state == ST_CMP);
  assign ctl.write  = commit && (grow || (act == sdit_pkg::ACT_REPLACED));
  assign ctl.shift  = grow;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_axis_tvalid) state_next = ST_CMP;
      ST_CMP:    state_next = ST_DEC;
      ST_DEC:    state_next = ST_COMMIT;
      ST_COMMIT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_key    <= s_axis_tdata[sdit_pkg::KEY_W-1:0];
      req_handle <= s_axis_tdata[sdit_pkg::KEY_W +: sdit_pkg::HANDLE_W];
    end
  end

  // Row of cells; each hands its key, handle and compare flag downstream.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign live[i] = (count > CW'(i));
    if (i == 0) begin : g_first
      assign prev_gt[i]     = 1'b1;
      assign prev_key[i]    = req_key;
      assign prev_handle[i] = req_handle;
    end else begin : g_rest
      assign prev_gt[i]     = gt[i-1];
      assign prev_key[i]    = key_row[i-1];
      assign prev_handle[i] = handle_row[i-1];
    end
    sdit_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_key     (req_key),
      .new_handle  (req_handle),
      .live        (live[i]),
      .prev_gt     (prev_gt[i]),
      .prev_key    (prev_key[i]),
      .prev_handle (prev_handle[i]),
      .gt          (gt[i]),
      .hit         (hit[i]),
      .eq          (eq[i]),
      .key         (key_row[i]),
      .handle      (handle_row[i])
    );
  end

  // hit is one-hot or empty (a full table with every stored key greater): OR-encode it.
  always_comb begin
    enc_pos = '0;
    repl    = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        enc_pos = enc_pos | CW'(i);
      end
      repl = repl | (hit[i] & eq[i]);
    end
  end

  always_comb begin
    pos_next = gt[CAPACITY-1] ? CW'(CAPACITY) : enc_pos;
    if (req_key == sdit_pkg::KEY_DEFAULT) begin
      pos_next = '0;
      act_next = sdit_pkg::ACT_IGNORED;
    end else if (repl) begin
      act_next = sdit_pkg::ACT_REPLACED;
    end else if (count == CW'(CAPACITY)) begin
      act_next = sdit_pkg::ACT_FULL;
    end else if (pos_next == count) begin
      act_next = sdit_pkg::ACT_APPENDED;
    end else begin
      act_next = sdit_pkg::ACT_INSERTED;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DEC) begin
      pos <= pos_next;
      act <= act_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit && grow) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_pos   <= sdit_pkg::POS_OUT_W'(pos);
      out_act   <= act;
      out_count <= grow ? sdit_pkg::COUNT_OUT_W'(count + CW'(1))
                        : sdit_pkg::COUNT_OUT_W'(count);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_count, out_act, out_pos};

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_hit_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEC) |-> $onehot0(hit))
    else $error("more than one slot hit");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + CW'(1)))
    else $error("entry count moved by other than one");

  a_full_no_grow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT && count == CW'(CAPACITY)) |-> !grow)
    else $error("growing commit into a full table");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted descending insert table.
// A short table of directed requests (empty table, key extremes, default key,
// replace, insert, append) is followed by random traffic. The random traffic
// mixes existing keys, keys just below the tail, extremes and fresh 64-bit
// keys, so the table fills to capacity and refusals and full-table replaces
// follow. Each accepted request goes through a behavioral copy of the table.
// Each returned result is matched field by field against the oldest pending
// prediction. Both stream sides idle at random, with one long stretch of
// back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_top;
  import sdit_pkg::*;

  localparam int CAPACITY   = CAPACITY_DEF;
  localparam int N_RANDOM   = 1135;
  localparam int IDLE_PCT   = 38;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic [POS_OUT_W-1:0]   pos;
    action_t                act;
    logic [COUNT_OUT_W-1:0] count;
  } result_t;

  typedef struct {
    logic [KEY_W-1:0]       key;
    logic [HANDLE_W-1:0]    handle;
    bit                     typed;  // expected result given in the row
    logic [POS_OUT_W-1:0]   pos;
    action_t                act;
    logic [COUNT_OUT_W-1:0] count;
  } stim_row_t;

  logic                  clk;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // behavioral copy of the table
  logic signed [KEY_W-1:0] tbl_key [CAPACITY];
  logic [HANDLE_W-1:0]     tbl_handle [CAPACITY];
  int                      tbl_count = 0;

  result_t pending_results [$];
  int      errors  = 0;
  bit      no_idle = 1'b0;

  stim_row_t dir_rows [15] = '{
    '{64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b1, 9'd0, ACT_IGNORED,  9'd0},
    '{64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 9'd0, ACT_APPENDED, 9'd1},
    '{64'h8000_0000_0000_0000, 32'h0000_0000, 1'b1, 9'd1, ACT_APPENDED, 9'd2},
    '{64'h7FFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b1, 9'd0, ACT_REPLACED, 9'd2},
    '{64'h0000_0000_0000_0000, 32'h0000_0001, 1'b0, 9'd0, ACT_IGNORED,  9'd0},
    '{64'hFFFF_FFFF_FFFF_FFFE, 32'h0000_0002, 1'b0, 9'd0, ACT_IGNORED,  9'd0},
    '{64'h0000_0000_0000_0000, 32'h0000_0003, 1'b0, 9'd0, ACT_IGNORED,  9'd0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0004, 1'b0, 9'd0, ACT_IGNORED,  9'd0},
    '{64'h8000_0000_0000_0000, 32'h0000_0005, 1'b0, 9'd0, ACT_IGNORED,  9'd0},
    '{64'h0000_0000_0000_0005, 32'hA5A5_A5A5, 1'b0, 9'd0, ACT_IGNORED,  9'd0},
    '{64'h7FFF_FFFF_FFFF_FFFE, 32'h5A5A_5A5A, 1'b0, 9'd0, ACT_IGNORED,  9'd0},
    '{64'h8000_0000_0000_0001, 32'h0000_FFFF, 1'b0, 9'd0, ACT_IGNORED,  9'd0},
    '{64'h0000_0001_0000_0000, 32'hFFFF_0000, 1'b0, 9'd0, ACT_IGNORED,  9'd0},
    '{64'hFFFF_FFFF_0000_0000, 32'h1234_5678, 1'b0, 9'd0, ACT_IGNORED,  9'd0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 9'd0, ACT_IGNORED,  9'd0}
  };

  sorted_descending_insert_table #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Place one entry in the behavioral table and return the result it gives.
  function automatic result_t place_entry(input logic signed [KEY_W-1:0] key,
                                          input logic [HANDLE_W-1:0] handle);
    result_t r;
    int      slot;
    r.pos = '0;
    r.act = ACT_IGNORED;
    if (key != KEY_DEFAULT) begin
      // table is descending, so keys not above the new one form a suffix
      slot = tbl_count;
      for (int i = tbl_count - 1; i >= 0; i--) begin
        if (key >= tbl_key[i]) slot = i;
      end
      r.pos = slot[POS_OUT_W-1:0];
      if (slot < tbl_count && tbl_key[slot] == key) r.act = ACT_REPLACED;
      else if (slot < tbl_count) r.act = ACT_INSERTED;
      else r.act = ACT_APPENDED;
      if (r.act != ACT_REPLACED && tbl_count >= CAPACITY) begin
        r.act = ACT_FULL;
      end else begin
        if (r.act != ACT_REPLACED) begin
          for (int i = tbl_count; i > slot; i--) begin
            tbl_key[i]    = tbl_key[i-1];
            tbl_handle[i] = tbl_handle[i-1];
          end
          tbl_count++;
        end
        tbl_key[slot]    = key;
        tbl_handle[slot] = handle;
      end
    end
    r.count = tbl_count[COUNT_OUT_W-1:0];
    return r;
  endfunction

  // Offer one request; on acceptance record what it must return.
  task automatic send_entry(input logic [KEY_W-1:0] key, input logic [HANDLE_W-1:0] handle,
                            input bit typed, input result_t given);
    result_t predicted;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {handle, key};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = place_entry(key, handle);
    pending_results.push_back(typed ? given : predicted);
  endtask

  always @(posedge clk) begin
    m_axis_tready <= !rst && (no_idle || $urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[8:0] !== want.pos) begin
          $display("%0t: position expected %0d actual %0d", $time, want.pos,
                   m_axis_tdata[8:0]);
          errors++;
        end
        if (m_axis_tdata[11:9] !== want.act) begin
          $display("%0t: action expected %0d actual %0d", $time, want.act,
                   m_axis_tdata[11:9]);
          errors++;
        end
        if (m_axis_tdata[20:12] !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                   m_axis_tdata[20:12]);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    result_t             given;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    int                  pick;
    int                  n_real;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      given.pos   = dir_rows[i].pos;
      given.act   = dir_rows[i].act;
      given.count = dir_rows[i].count;
      send_entry(dir_rows[i].key, dir_rows[i].handle, dir_rows[i].typed, given);
    end

    n_real = 0;
    while (n_real < N_RANDOM) begin
      no_idle = (n_real >= 400 && n_real < 600);
      pick    = $urandom_range(99);
      handle  = $urandom;
      if (pick < 6) begin
        key = KEY_DEFAULT;
      end else if (pick < 40 && tbl_count > 0) begin
        key = tbl_key[$urandom_range(tbl_count - 1)];
      end else if (pick < 46 && tbl_count > 0 && tbl_key[tbl_count-1] > KEY_MIN + 64'sd1000) begin
        // just below the tail: append, or refusal at position CAPACITY
        key = tbl_key[tbl_count-1] - 64'($urandom_range(1000, 1));
      end else if (pick < 50) begin
        case ($urandom_range(3))
          0:       key = KEY_MAX;
          1:       key = KEY_MIN;
          2:       key = '0;
          default: key = 64'hFFFF_FFFF_FFFF_FFFE;
        endcase
      end else begin
        key = {$urandom, $urandom};
      end
      n_real++;
      send_entry(key, handle, 1'b0, given);
    end
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/sdit_pkg.sv
rtl/core/sdit_cell.sv
rtl/core/sorted_descending_insert_table.sv
tb/tb_top.sv
